[design/voxel_view_visibility_clear_assert.svh]
// ----------------------------------------------------------------------------
// voxel view visibility clear assertion macros
// shared clocked assertion forms, reset disables the check
// ----------------------------------------------------------------------------
`ifndef VOXEL_VIEW_VISIBILITY_CLEAR_ASSERT_SVH
`define VOXEL_VIEW_VISIBILITY_CLEAR_ASSERT_SVH

// condition that holds at every edge out of reset
`define VVC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence that follows in the cycle after a trigger
`define VVC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

[design/vvc_pkg.sv]
// ----------------------------------------------------------------------------
// vvc_pkg
// shared types, field offsets and helpers of the visibility clear block
// ----------------------------------------------------------------------------
`default_nettype none

package vvc_pkg;

  // words per view slot
  localparam int WPV = 18;

  // word indexes with a fixed meaning
  localparam logic [4:0] WI_TX = 5'd3;
  localparam logic [4:0] WI_FX = 5'd12;
  localparam logic [4:0] WI_FY = 5'd13;
  localparam logic [4:0] WI_CX = 5'd14;
  localparam logic [4:0] WI_W  = 5'd16;
  localparam logic [4:0] WI_H  = 5'd17;

  // stream widths
  localparam int IN_W  = 104;
  localparam int OUT_W = 16;

  // divider widths: dividend 2|num|+d, divisor 2d
  localparam int DVD_W = 65;
  localparam int DVS_W = 48;

  // accumulator and saturation widths
  localparam int ACC_W = 52;

  typedef enum logic [1:0] {
    CMD_WORD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_INVAL = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_VSIZE  = 3'd0,
    CFG_ORG_X  = 3'd1,
    CFG_ORG_Y  = 3'd2,
    CFG_ORG_Z  = 3'd3,
    CFG_SPH_X  = 3'd4,
    CFG_SPH_Y  = 3'd5,
    CFG_SPH_Z  = 3'd6,
    CFG_RADIUS = 3'd7
  } cfg_idx_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CEN_MUL, OP_CEN_ADD, OP_SPH_DIF, OP_SPH_MUL, OP_SPH_ACC,
    OP_RAD_MUL, OP_SPH_CHK, OP_TR_LDT, OP_TR_MUL, OP_TR_ADD, OP_TR_SAT,
    OP_PJ_MULF, OP_PJ_LDF, OP_PJ_MULC, OP_PJ_ADDC, OP_PJ_DIV, OP_PJ_CHK,
    OP_DP_CMP, OP_OUT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CEN_MUL, ST_CEN_ADD, ST_SPH_DIF, ST_SPH_MUL, ST_SPH_ACC,
    ST_RAD_MUL, ST_SPH_CHK, ST_VW_CHK, ST_TR_LDT, ST_TR_MUL, ST_TR_ADD,
    ST_TR_SAT, ST_PJ_ZCHK, ST_PJ_MULF, ST_PJ_LDF, ST_PJ_MULC, ST_PJ_ADDC,
    ST_PJ_DIV, ST_PJ_WAIT, ST_PJ_CHK, ST_DP_RD, ST_DP_CMP, ST_VW_NEXT, ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] k;
    logic [1:0] j;
    logic       m;
    logic [4:0] widx;
  } dp_cmd_t;

  typedef struct packed {
    logic view_ok;
    logic z_pos;
    logic div_busy;
    logic pix_ok;
    logic hit;
    logic in_sph;
    logic out_busy;
  } dp_stat_t;

  // clamp a wide signed value to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic same;
    same = (v[ACC_W-1:31] == '0) || (v[ACC_W-1:31] == '1);
    if (same) begin
      return v[31:0];
    end else if (v[ACC_W-1]) begin
      return 32'sh8000_0000;
    end
    return 32'sh7fff_ffff;
  endfunction

endpackage

`default_nettype wire

[design/vvc_div.sv]
// ----------------------------------------------------------------------------
// vvc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module vvc_div
  import vvc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dvd,
  input  wire logic [DVS_W-1:0] dvs,
  output logic                  busy,
  output logic [DVD_W-1:0]      quo
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs_q;
  logic [CW-1:0]    cnt;
  logic [DVS_W:0]   trial;
  logic             qbit;

  // trial subtract of the next dividend bit
  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    qbit  = (trial >= {1'b0, dvs_q});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DVD_W);
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dvd;
      dvs_q <= dvs;
    end else if (busy) begin
      rem <= qbit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      quo <= {quo[DVD_W-2:0], qbit};
    end
  end

endmodule

`default_nettype wire

[design/vvc_dp.sv]
// ----------------------------------------------------------------------------
// vvc_dp
// datapath: config, view and depth stores, multiplier, divider, result word
// ----------------------------------------------------------------------------
`default_nettype none

module vvc_dp
  import vvc_pkg::*;
#(
  parameter int MAX_VIEWS = 8,
  parameter int IMG_W     = 128,
  parameter int IMG_H     = 128,
  parameter int VIW       = 3
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [31:0]     cfg_data,
  input  wire logic            in_acc,
  input  wire logic [1:0]      in_cmd,
  input  wire logic [IN_W-1:0] in_data,
  input  wire dp_cmd_t         c,
  input  wire logic [VIW-1:0]  view,
  output dp_stat_t             stat,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [OUT_W-1:0]     out_data
);

  localparam int WDEPTH = MAX_VIEWS * WPV;
  localparam int WAW    = $clog2(WDEPTH);
  localparam int DDEPTH = MAX_VIEWS * IMG_W * IMG_H;
  localparam int DAW    = $clog2(DDEPTH);
  localparam int UW     = $clog2(IMG_W);
  localparam int VW     = $clog2(IMG_H);

  // input fields
  logic [2:0]  f_view;
  logic [4:0]  f_widx;
  logic [31:0] f_word;
  logic [6:0]  f_px;
  logic [6:0]  f_py;
  logic [15:0] f_depth;
  logic [7:0]  f_vox [3];
  logic [7:0]  f_val;

  assign f_view   = in_data[2:0];
  assign f_widx   = in_data[7:3];
  assign f_word   = in_data[39:8];
  assign f_px     = in_data[46:40];
  assign f_py     = in_data[53:47];
  assign f_depth  = in_data[69:54];
  assign f_vox[0] = in_data[77:70];
  assign f_vox[1] = in_data[85:78];
  assign f_vox[2] = in_data[93:86];
  assign f_val    = in_data[101:94];

  // config registers
  logic [30:0]        vsize;
  logic signed [31:0] org [3];
  logic signed [31:0] sph [3];
  logic [30:0]        radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      vsize  <= 31'd3277;
      org[0] <= '0;
      org[1] <= '0;
      org[2] <= '0;
      sph[0] <= '0;
      sph[1] <= '0;
      sph[2] <= '0;
      radius <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_VSIZE:  vsize  <= cfg_data[30:0];
        CFG_ORG_X:  org[0] <= cfg_data;
        CFG_ORG_Y:  org[1] <= cfg_data;
        CFG_ORG_Z:  org[2] <= cfg_data;
        CFG_SPH_X:  sph[0] <= cfg_data;
        CFG_SPH_Y:  sph[1] <= cfg_data;
        CFG_SPH_Z:  sph[2] <= cfg_data;
        CFG_RADIUS: radius <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // load decode
  logic view_in_range;
  logic word_we;
  logic pix_we;

  always_comb begin
    view_in_range = (32'(f_view) < MAX_VIEWS);
    word_we = in_acc && (in_cmd == CMD_WORD) && view_in_range && (32'(f_widx) < WPV);
    pix_we  = in_acc && (in_cmd == CMD_PIXEL) && view_in_range &&
              (32'(f_px) < IMG_W) && (32'(f_py) < IMG_H);
  end

  // view valid bits
  logic [MAX_VIEWS-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (in_acc && (in_cmd == CMD_INVAL)) begin
      valid <= '0;
    end else if (word_we && (f_widx == WI_H)) begin
      valid[VIW'(f_view)] <= 1'b1;
    end
  end

  // view word store
  logic [31:0] wmem [WDEPTH];
  logic [31:0] wrd;

  always_ff @(posedge clk) begin
    if (word_we) begin
      wmem[WAW'(int'(f_view) * WPV + int'(f_widx))] <= f_word;
    end
    wrd <= wmem[WAW'(int'(view) * WPV + int'(c.widx))];
  end

  // depth store
  logic [15:0]   dmem [DDEPTH];
  logic [15:0]   drd;
  logic [UW-1:0] ureg;
  logic [VW-1:0] vreg;

  always_ff @(posedge clk) begin
    if (pix_we) begin
      dmem[DAW'(int'(f_view) * IMG_W * IMG_H + int'(f_py) * IMG_W + int'(f_px))] <= f_depth;
    end
    drd <= dmem[DAW'(int'(view) * IMG_W * IMG_H + int'(vreg) * IMG_W + int'(ureg))];
  end

  // shared multiplier, registered product
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;
  logic [7:0]         idx [3];
  logic signed [31:0] p   [3];
  logic signed [31:0] loc [3];
  logic [32:0]        adiff;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (c.op)
      OP_CEN_MUL: begin
        mul_a = {24'b0, idx[c.k], 1'b1};
        mul_b = {2'b0, vsize};
      end
      OP_SPH_MUL: begin
        mul_a = {1'b0, adiff[31:0]};
        mul_b = {1'b0, adiff[31:0]};
      end
      OP_RAD_MUL: begin
        mul_a = {2'b0, radius};
        mul_b = {2'b0, radius};
      end
      OP_TR_MUL: begin
        mul_a = {wrd[31], wrd};
        mul_b = {p[c.j][31], p[c.j]};
      end
      OP_PJ_MULF: begin
        mul_a = {wrd[31], wrd};
        mul_b = {loc[{1'b0, c.m}][31], loc[{1'b0, c.m}]};
      end
      OP_PJ_MULC: begin
        mul_a = {wrd[31], wrd};
        mul_b = {loc[2][31], loc[2]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // centre, distance and projection arithmetic
  logic signed [ACC_W-1:0] cen_sum;
  logic signed [32:0]      dif;
  logic [32:0]             dif_abs;
  logic signed [64:0]      num;
  logic signed [64:0]      num_neg;
  logic [63:0]             num_abs;
  logic [DVD_W-1:0]        dvd;
  logic [DVS_W-1:0]        dvs;
  logic [DVD_W-1:0]        quo;
  logic                    div_busy;
  logic                    neg;
  logic signed [ACC_W-1:0] acc;
  logic [63:0]             sum;
  logic                    far;
  logic                    in_sph;
  logic                    seen;
  logic [7:0]              val;
  logic                    pix_ok;
  logic                    hit;
  logic [41:0]             lhs;
  logic [41:0]             rhs;
  int                      lim;

  always_comb begin
    cen_sum = {{(ACC_W - 32){org[c.k][31]}}, org[c.k]} +
              {{(ACC_W - 40){1'b0}}, prod[40:1]};
    dif     = {p[c.k][31], p[c.k]} - {sph[c.k][31], sph[c.k]};
    dif_abs = dif[32] ? 33'(-dif) : 33'(dif);
    num_neg = -num;
    num_abs = num[64] ? num_neg[63:0] : num[63:0];
    dvd     = {num_abs, 1'b0} + {18'b0, loc[2][30:0], 16'b0};
    dvs     = {loc[2][30:0], 17'b0};
    lim     = c.m ? IMG_H : IMG_W;
    pix_ok  = (!neg || (quo == '0)) && (quo < DVD_W'(lim)) &&
              ($signed(wrd) > 0) && (quo < {33'b0, wrd});
    lhs     = {11'b0, loc[2][30:0]} * 42'd1000;
    rhs     = {10'b0, drd, 16'b0} + ({11'b0, vsize} * 42'd1000);
    hit     = (lhs < rhs);
  end

  vvc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (c.op == OP_PJ_DIV),
    .dvd   (dvd),
    .dvs   (dvs),
    .busy  (div_busy),
    .quo   (quo)
  );

  // working registers
  always_ff @(posedge clk) begin
    if (in_acc && (in_cmd == CMD_QUERY)) begin
      idx[0] <= f_vox[0];
      idx[1] <= f_vox[1];
      idx[2] <= f_vox[2];
      val    <= f_val;
      far    <= 1'b0;
      sum    <= '0;
      seen   <= 1'b0;
    end
    case (c.op)
      OP_CEN_ADD: p[c.k] <= sat32(cen_sum);
      OP_SPH_DIF: begin
        adiff <= dif_abs;
        if (dif_abs > {2'b0, radius}) begin
          far <= 1'b1;
        end
      end
      OP_SPH_ACC: begin
        if (adiff <= {2'b0, radius}) begin
          sum <= sum + prod[63:0];
        end
      end
      OP_SPH_CHK: in_sph <= !far && (sum <= prod[63:0]);
      OP_TR_LDT:  acc <= {{(ACC_W - 32){wrd[31]}}, wrd};
      OP_TR_ADD:  acc <= acc + ACC_W'(prod >>> 16);
      OP_TR_SAT:  loc[c.k] <= sat32(acc);
      OP_PJ_LDF:  num <= prod[64:0];
      OP_PJ_ADDC: num <= num + prod[64:0];
      OP_PJ_DIV:  neg <= num[64];
      OP_PJ_CHK: begin
        if (pix_ok && !c.m) begin
          ureg <= quo[UW-1:0];
        end
        if (pix_ok && c.m) begin
          vreg <= quo[VW-1:0];
        end
      end
      OP_DP_CMP: begin
        if (hit) begin
          seen <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result word register
  logic [7:0] out_value;
  logic       out_clr;
  logic       out_ins;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c.op == OP_OUT) begin
      out_value <= (in_sph && !seen) ? 8'd0 : val;
      out_clr   <= in_sph && !seen;
      out_ins   <= in_sph;
    end
  end

  assign out_data = {6'b0, out_ins, out_clr, out_value};

  // status to the controller
  always_comb begin
    stat.view_ok  = valid[view];
    stat.z_pos    = (loc[2] > 0);
    stat.div_busy = div_busy;
    stat.pix_ok   = pix_ok;
    stat.hit      = hit;
    stat.in_sph   = in_sph;
    stat.out_busy = out_valid && !out_ready;
  end

endmodule

`default_nettype wire

[design/vvc_ctrl.sv]
// ----------------------------------------------------------------------------
// vvc_ctrl
// sequencer for one query: centre, sphere test, per view transform and test
// ----------------------------------------------------------------------------
`default_nettype none

`include "voxel_view_visibility_clear_assert.svh"

module vvc_ctrl
  import vvc_pkg::*;
#(
  parameter int MAX_VIEWS = 8,
  parameter int VIW       = 3
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_acc,
  input  wire dp_stat_t       stat,
  output dp_cmd_t             c,
  output logic [VIW-1:0]      view,
  output logic                idle
);

  localparam int VCW = $clog2(MAX_VIEWS + 1);

  ctrl_state_t    state, state_next;
  logic [1:0]     k, k_next;
  logic [1:0]     j, j_next;
  logic           m, m_next;
  logic [VCW-1:0] vcnt, vcnt_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
      j     <= '0;
      m     <= 1'b0;
      vcnt  <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
      j     <= j_next;
      m     <= m_next;
      vcnt  <= vcnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    k_next     = k;
    j_next     = j;
    m_next     = m;
    vcnt_next  = vcnt;
    c.op       = OP_NONE;
    c.k        = k;
    c.j        = j;
    c.m        = m;
    c.widx     = '0;
    unique case (state)
      ST_IDLE: begin
        if (q_acc) begin
          k_next     = '0;
          state_next = ST_CEN_MUL;
        end
      end
      ST_CEN_MUL: begin
        c.op       = OP_CEN_MUL;
        state_next = ST_CEN_ADD;
      end
      ST_CEN_ADD: begin
        c.op       = OP_CEN_ADD;
        state_next = ST_SPH_DIF;
      end
      ST_SPH_DIF: begin
        c.op       = OP_SPH_DIF;
        state_next = ST_SPH_MUL;
      end
      ST_SPH_MUL: begin
        c.op       = OP_SPH_MUL;
        state_next = ST_SPH_ACC;
      end
      ST_SPH_ACC: begin
        c.op = OP_SPH_ACC;
        if (k == 2'd2) begin
          state_next = ST_RAD_MUL;
        end else begin
          k_next     = k + 2'd1;
          state_next = ST_CEN_MUL;
        end
      end
      ST_RAD_MUL: begin
        c.op       = OP_RAD_MUL;
        state_next = ST_SPH_CHK;
      end
      ST_SPH_CHK: begin
        c.op       = OP_SPH_CHK;
        vcnt_next  = '0;
        state_next = ST_VW_CHK;
      end
      ST_VW_CHK: begin
        c.widx = WI_TX;
        if (!stat.in_sph || (vcnt == VCW'(MAX_VIEWS))) begin
          state_next = ST_FIN;
        end else if (stat.view_ok) begin
          k_next     = '0;
          state_next = ST_TR_LDT;
        end else begin
          vcnt_next = vcnt + 1'b1;
        end
      end
      ST_TR_LDT: begin
        c.op       = OP_TR_LDT;
        c.widx     = {1'b0, k, 2'b00};
        j_next     = '0;
        state_next = ST_TR_MUL;
      end
      ST_TR_MUL: begin
        c.op       = OP_TR_MUL;
        state_next = ST_TR_ADD;
      end
      ST_TR_ADD: begin
        c.op = OP_TR_ADD;
        if (j == 2'd2) begin
          state_next = ST_TR_SAT;
        end else begin
          j_next     = j + 2'd1;
          c.widx     = {1'b0, k, 2'b00} + {3'b0, j} + 5'd1;
          state_next = ST_TR_MUL;
        end
      end
      ST_TR_SAT: begin
        c.op = OP_TR_SAT;
        if (k == 2'd2) begin
          c.widx     = WI_FX;
          m_next     = 1'b0;
          state_next = ST_PJ_ZCHK;
        end else begin
          c.widx     = {1'b0, k, 2'b00} + 5'd7;
          k_next     = k + 2'd1;
          state_next = ST_TR_LDT;
        end
      end
      ST_PJ_ZCHK: begin
        c.widx     = WI_FX;
        state_next = stat.z_pos ? ST_PJ_MULF : ST_VW_NEXT;
      end
      ST_PJ_MULF: begin
        c.op       = OP_PJ_MULF;
        state_next = ST_PJ_LDF;
      end
      ST_PJ_LDF: begin
        c.op       = OP_PJ_LDF;
        c.widx     = WI_CX + {4'b0, m};
        state_next = ST_PJ_MULC;
      end
      ST_PJ_MULC: begin
        c.op       = OP_PJ_MULC;
        state_next = ST_PJ_ADDC;
      end
      ST_PJ_ADDC: begin
        c.op       = OP_PJ_ADDC;
        state_next = ST_PJ_DIV;
      end
      ST_PJ_DIV: begin
        c.op       = OP_PJ_DIV;
        state_next = ST_PJ_WAIT;
      end
      ST_PJ_WAIT: begin
        c.widx = WI_W + {4'b0, m};
        if (!stat.div_busy) begin
          state_next = ST_PJ_CHK;
        end
      end
      ST_PJ_CHK: begin
        c.op   = OP_PJ_CHK;
        c.widx = WI_FY;
        if (!stat.pix_ok) begin
          state_next = ST_VW_NEXT;
        end else if (!m) begin
          m_next     = 1'b1;
          state_next = ST_PJ_MULF;
        end else begin
          state_next = ST_DP_RD;
        end
      end
      ST_DP_RD: begin
        state_next = ST_DP_CMP;
      end
      ST_DP_CMP: begin
        c.op       = OP_DP_CMP;
        state_next = stat.hit ? ST_FIN : ST_VW_NEXT;
      end
      ST_VW_NEXT: begin
        vcnt_next  = vcnt + 1'b1;
        state_next = ST_VW_CHK;
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          c.op       = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign view = vcnt[VIW-1:0];
  assign idle = (state == ST_IDLE);

  // checks
  `VVC_ASSERT_NEXT(a_div_runs, state == ST_PJ_DIV, stat.div_busy, "divider did not start")
  `VVC_ASSERT_ALWAYS(a_vcnt_range, vcnt <= VCW'(MAX_VIEWS), "view counter out of range")
  `VVC_ASSERT_ALWAYS(a_tr_in_sph, (state != ST_TR_LDT) || stat.in_sph, "view walk outside sphere")
  `VVC_ASSERT_ALWAYS(a_cmp_zpos, (state != ST_DP_CMP) || stat.z_pos, "depth test with z not positive")

endmodule

`default_nettype wire

[design/voxel_view_visibility_clear.sv]
// ----------------------------------------------------------------------------
// voxel_view_visibility_clear
// space carving test of one voxel against up to MAX_VIEWS depth views
// ----------------------------------------------------------------------------
// Input words arrive on the s_ stream, tuser carrying the command. Loads of
// view words and depth pixels and the invalidate command give no result.
// A query word gives exactly one m_ stream word. A query first works out
// the voxel centre and runs the sphere test, then walks the valid views:
// for each one a slot check, the transform, a z check, two projections each
// bound by the restoring divider, then the depth read and compare and a
// step on to the next view. Invalid views are only stepped over, and the
// walk stops at the first view that sees the voxel.
// One query is in work at a time; s_tready is high only while idle.
// The result sits in an output register: the next words are taken while it
// waits, and a new query result waits until m_tready frees the register.
// Reset clears config to its defaults, all view valid bits and the result
// valid flag; view words and depth pixels keep no reset value.
// Config writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_view_visibility_clear
  import vvc_pkg::*;
#(
  parameter int MAX_VIEWS = 8,
  parameter int IMG_W     = 128,
  parameter int IMG_H     = 128
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // config write port
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_index,
  input  wire logic [31:0]      cfg_data,
  // input stream
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // view_index, word_index, word_value, pixel_x, pixel_y, depth_mm,
  // voxel_x, voxel_y, voxel_z, voxel_value, zero fill
  input  wire logic [IN_W-1:0]  s_tdata,
  // cmd
  input  wire logic [1:0]       s_tuser,
  // result stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // value_out, was_cleared, inside_sphere, zero fill
  output logic [OUT_W-1:0]      m_tdata
);

  localparam int VIW = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;

  logic           in_acc;
  logic           q_acc;
  logic           idle;
  dp_cmd_t        c;
  dp_stat_t       stat;
  logic [VIW-1:0] view;

  // input word handshake
  assign s_tready = idle;
  assign in_acc   = s_tvalid && s_tready;
  assign q_acc    = in_acc && (s_tuser == CMD_QUERY);

  vvc_ctrl #(
    .MAX_VIEWS (MAX_VIEWS),
    .VIW       (VIW)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .q_acc (q_acc),
    .stat  (stat),
    .c     (c),
    .view  (view),
    .idle  (idle)
  );

  vvc_dp #(
    .MAX_VIEWS (MAX_VIEWS),
    .IMG_W     (IMG_W),
    .IMG_H     (IMG_H),
    .VIW       (VIW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_acc    (in_acc),
    .in_cmd    (s_tuser),
    .in_data   (s_tdata),
    .c         (c),
    .view      (view),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire

[dv/vvc_visibility_checker.sv]
// ----------------------------------------------------------------------------
// vvc_visibility_checker
// watches the config port and both streams, keeps its own copy of the view
// store and config, predicts the verdict of every query word and compares it
// field by field with the result words in order
// ----------------------------------------------------------------------------
`default_nettype none

module vvc_visibility_checker
  import vvc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [103:0] s_tdata,
  input  wire logic [1:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [15:0]  m_tdata,
  output int                errors,
  output int                pending
);

  typedef logic signed [127:0] wide_t;

  // packed from the top bit down: inside_sphere, was_cleared, value_out
  typedef struct packed {
    logic       in_sph;
    logic       cleared;
    logic [7:0] value;
  } verdict_t;

  localparam wide_t S32_MAX = 128'sh7fff_ffff;
  localparam wide_t S32_MIN = -128'sh8000_0000;

  verdict_t           verdicts[$];
  logic [30:0]        vsize;
  logic [30:0]        radius;
  logic signed [31:0] origin[3];
  logic signed [31:0] centre[3];
  logic signed [31:0] words[8][WPV];
  bit                 valid[8];
  logic [15:0]        depth_img[8][128][128];

  initial errors = 0;
  initial pending = 0;

  function automatic wide_t clamp32(wide_t v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // divide rounding half away from zero, den positive
  function automatic wide_t div_round(wide_t num, wide_t den);
    wide_t a;
    wide_t q;
    a = (num < 0) ? -num : num;
    q = (2 * a + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  // does view v see the point (x, y, z)
  function automatic bit view_sees(int v, wide_t x, wide_t y, wide_t z);
    wide_t pt[3];
    wide_t loc[3];
    wide_t acc;
    wide_t w;
    wide_t lz;
    wide_t u;
    wide_t vv;
    wide_t d;
    wide_t vs;
    pt[0] = x;
    pt[1] = y;
    pt[2] = z;
    for (int k = 0; k < 3; k++) begin
      acc = words[v][4 * k + 3];
      for (int j = 0; j < 3; j++) begin
        w = words[v][4 * k + j];
        acc = acc + ((w * pt[j]) >>> 16);
      end
      loc[k] = clamp32(acc);
    end
    lz = loc[2];
    if (lz <= 0) return 0;
    w = words[v][WI_FX];
    acc = words[v][WI_CX];
    u = div_round(loc[0] * w + acc * lz, lz * 65536);
    w = words[v][WI_FY];
    acc = words[v][WI_CX + 1];
    vv = div_round(loc[1] * w + acc * lz, lz * 65536);
    w = words[v][WI_W];
    acc = words[v][WI_H];
    if (u < 0 || vv < 0 || u >= w || vv >= acc || u >= 128 || vv >= 128) return 0;
    d = depth_img[v][vv[6:0]][u[6:0]];
    vs = vsize;
    return (1000 * lz) < (d * 65536 + 1000 * vs);
  endfunction

  function automatic verdict_t carve(logic [7:0] vx, logic [7:0] vy, logic [7:0] vz,
                                     logic [7:0] value);
    wide_t idx[3];
    wide_t p[3];
    wide_t a;
    wide_t r;
    wide_t vs;
    wide_t sum;
    wide_t o;
    bit in_sph;
    bit seen;
    verdict_t res;
    idx[0] = vx;
    idx[1] = vy;
    idx[2] = vz;
    vs = vsize;
    r = radius;
    sum = 0;
    in_sph = 1;
    seen = 0;
    // voxel centre and sphere test
    for (int k = 0; k < 3; k++) begin
      o = origin[k];
      p[k] = clamp32(o + (((2 * idx[k] + 1) * vs) >>> 1));
      o = centre[k];
      a = p[k] - o;
      if (a < 0) a = -a;
      if (a > r) in_sph = 0;
      else sum = sum + a * a;
    end
    if (in_sph && sum > r * r) in_sph = 0;
    // walk the valid views
    if (in_sph) begin
      for (int v = 0; v < 8; v++) begin
        if (!seen && valid[v] && view_sees(v, p[0], p[1], p[2])) seen = 1;
      end
    end
    res.cleared = in_sph && !seen;
    res.in_sph = in_sph;
    res.value = res.cleared ? 8'd0 : value;
    return res;
  endfunction

  // append one expected verdict at the tail
  task automatic enqueue_verdict(verdict_t vd);
    verdicts.insert(verdicts.size(), vd);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (rst) begin
      vsize = 31'd3277;
      radius = 31'd65536;
      for (int k = 0; k < 3; k++) begin
        origin[k] = 0;
        centre[k] = 0;
      end
      for (int v = 0; v < 8; v++) valid[v] = 0;
      verdicts.delete();
    end else begin
      // config writes
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_VSIZE:  vsize = cfg_data[30:0];
          CFG_ORG_X:  origin[0] = cfg_data;
          CFG_ORG_Y:  origin[1] = cfg_data;
          CFG_ORG_Z:  origin[2] = cfg_data;
          CFG_SPH_X:  centre[0] = cfg_data;
          CFG_SPH_Y:  centre[1] = cfg_data;
          CFG_SPH_Z:  centre[2] = cfg_data;
          CFG_RADIUS: radius = cfg_data[30:0];
          default: ;
        endcase
      end
      // input words
      if (s_tvalid && s_tready) begin
        case (cmd_t'(s_tuser))
          CMD_WORD: begin
            if (s_tdata[7:3] < WPV) begin
              words[s_tdata[2:0]][s_tdata[7:3]] = s_tdata[39:8];
              if (s_tdata[7:3] == WI_H) valid[s_tdata[2:0]] = 1;
            end
          end
          CMD_PIXEL: depth_img[s_tdata[2:0]][s_tdata[53:47]][s_tdata[46:40]] = s_tdata[69:54];
          CMD_QUERY: enqueue_verdict(carve(s_tdata[77:70], s_tdata[85:78],
                                           s_tdata[93:86], s_tdata[101:94]));
          CMD_INVAL: for (int v = 0; v < 8; v++) valid[v] = 0;
          default: ;
        endcase
      end
      // result words
      if (m_tvalid && m_tready) begin
        got = m_tdata[9:0];
        if (verdicts.size() == 0) begin
          report_mismatch("unexpected result word", m_tdata, 0);
        end else begin
          want = verdicts.pop_front();
          if (got.value != want.value) report_mismatch("value_out", got.value, want.value);
          if (got.cleared != want.cleared)
            report_mismatch("was_cleared", got.cleared, want.cleared);
          if (got.in_sph != want.in_sph)
            report_mismatch("inside_sphere", got.in_sph, want.in_sph);
        end
      end
    end
    pending = verdicts.size();
  end

endmodule

`default_nettype wire

[dv/tb_voxel_view_visibility_clear.sv]
// ----------------------------------------------------------------------------
// tb_voxel_view_visibility_clear
// stimulus for the visibility clear block: sets up four depth views, runs
// directed corner queries, then five config phases of mixed random loads,
// queries and invalidates with idling on both streams; the checker judges
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voxel_view_visibility_clear;
  import vvc_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int PHASE_ITEMS = 260;

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [2:0]    cfg_index;
  logic [31:0]   cfg_data;
  logic          s_tvalid;
  logic          s_tready;
  // view_index, word_index, word_value, pixel_x, pixel_y, depth_mm,
  // voxel_x, voxel_y, voxel_z, voxel_value, zero fill
  logic [103:0]  s_tdata;
  // cmd
  logic [1:0]    s_tuser;
  logic          m_tvalid;
  logic          m_tready;
  // value_out, was_cleared, inside_sphere, zero fill
  logic [15:0]   m_tdata;
  int            errors;
  int            pending;
  int            idle_cycles;
  int            rx_stall;
  bit            calm;
  logic [31:0]   cfgv[8];
  int            views_used[4] = '{0, 3, 5, 6};
  int            views_spare[4] = '{1, 2, 4, 7};

  voxel_view_visibility_clear u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  vvc_visibility_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(errors), .pending(pending)
  );

  initial clk = 0;
  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // result side stalls in random bursts
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
      rx_stall = 0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rx_stall = $urandom_range(1, 17) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("voxel_view_visibility_clear verification failed");
        $finish;
      end
    end
  end

  // one input word, with a random gap in front
  task automatic push(cmd_t c, logic [103:0] d);
    if (!calm && $urandom_range(0, 6) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // unused fields carry random bits
  function automatic logic [103:0] noise();
    logic [127:0] r;
    r = {$urandom, $urandom, $urandom, $urandom};
    return r[103:0];
  endfunction

  task automatic send_word(int v, int widx, logic [31:0] val);
    logic [103:0] d;
    d = noise();
    d[2:0] = 3'(v);
    d[7:3] = 5'(widx);
    d[39:8] = val;
    push(CMD_WORD, d);
  endtask

  task automatic send_pixel(int v, int px, int py, int dmm);
    logic [103:0] d;
    d = noise();
    d[2:0] = 3'(v);
    d[46:40] = 7'(px);
    d[53:47] = 7'(py);
    d[69:54] = 16'(dmm);
    push(CMD_PIXEL, d);
  endtask

  task automatic send_query(int vx, int vy, int vz, int val);
    logic [103:0] d;
    d = noise();
    d[77:70] = 8'(vx);
    d[85:78] = 8'(vy);
    d[93:86] = 8'(vz);
    d[101:94] = 8'(val);
    push(CMD_QUERY, d);
  endtask

  // nominal view word: near identity pose, 8x8 image centred at 4,4
  function automatic logic [31:0] view_base(int widx);
    case (widx)
      0, 5, 10: return 32'd65536;
      3, 7:     return -32'sd32768;
      11:       return 32'd81920;
      12, 13, 14, 15: return 32'd262144;
      16, 17:   return 32'd8;
      default:  return 32'd0;
    endcase
  endfunction

  function automatic logic [31:0] jitter(int widx);
    if (widx >= WI_W || $urandom_range(0, 6) == 0) return (widx >= WI_W) ? view_base(widx)
                                                                        : $urandom;
    return view_base(widx) + $urandom_range(0, 16384) - 8192;
  endfunction

  // depth image first, then the words, word 17 last makes it valid
  task automatic setup_view(int v);
    for (int y = 0; y < 8; y++) begin
      for (int x = 0; x < 8; x++) begin
        send_pixel(v, x, y, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(300, 3000));
      end
    end
    for (int w = 0; w < WPV; w++) send_word(v, w, jitter(w));
  endtask

  // drain all results and let the block settle before config writes
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_config();
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= cfgv[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int r;
    int v;
    int w;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send_query($urandom_range(0, 30), $urandom_range(0, 30), $urandom_range(0, 30),
                 $urandom_range(0, 255));
    end else if (r < 55) begin
      send_query($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255));
    end else if (r < 70) begin
      v = ($urandom_range(0, 1) == 0) ? views_used[$urandom_range(0, 3)] : $urandom_range(0, 7);
      if ($urandom_range(0, 4) < 3) begin
        send_pixel(v, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 65535));
      end else begin
        send_pixel(v, $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 3000));
      end
    end else if (r < 80) begin
      w = $urandom_range(0, 15);
      send_word(views_used[$urandom_range(0, 3)], w, jitter(w));
    end else if (r < 85) begin
      // image size, zero or negative sizes included
      send_word(views_used[$urandom_range(0, 3)], $urandom_range(WI_W, WI_H),
                $urandom_range(0, 10) - 2 > 8 ? 8 : $urandom_range(0, 10) - 2);
    end else if (r < 90) begin
      // spare slots never become valid; indexes above 17 are ignored
      w = $urandom_range(0, 31);
      if (w == WI_H) w = 18;
      send_word(views_spare[$urandom_range(0, 3)], w, $urandom);
    end else if (r < 93) begin
      push(CMD_INVAL, noise());
    end else begin
      send_word(views_used[$urandom_range(0, 3)], WI_H, 8);
    end
  endtask

  initial begin
    calm = 0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= CMD_WORD;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (views_used[i]) setup_view(views_used[i]);

    // directed corners under reset config
    send_query(0, 0, 0, 0);
    send_query(255, 255, 255, 255);
    send_query(10, 10, 2, 8'h5a);
    send_word(1, 18, $urandom);
    send_word(1, 31, $urandom);
    send_pixel(0, 4, 4, 0);
    send_query(10, 10, 2, 8'ha5);
    send_pixel(0, 4, 4, 65535);
    send_query(10, 10, 2, 8'h0f);
    // non-positive width
    send_word(0, WI_W, 0);
    send_query(10, 10, 2, 8'hf0);
    send_word(0, WI_W, -3);
    send_query(10, 10, 2, 8'h33);
    send_word(0, WI_W, 8);
    // invalidate, then bring two views back
    push(CMD_INVAL, noise());
    send_query(10, 10, 2, 8'hcc);
    send_word(0, WI_H, 8);
    send_word(3, WI_H, 8);
    send_query(10, 10, 2, 8'h77);
    // rewrite a word of a valid view
    send_word(5, 11, 32'd98304);
    send_query(12, 9, 3, 8'h88);

    for (int ph = 0; ph < 5; ph++) begin
      wait_idle();
      case (ph)
        0: cfgv = '{32'd3277, 32'd0, 32'd0, 32'd0, 32'd19661, 32'd19661, 32'd19661, 32'd65536};
        1: cfgv = '{32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        2: cfgv = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff};
        3: foreach (cfgv[i]) cfgv[i] = $urandom;
        default: cfgv = '{32'd6554, -32'sd32768, -32'sd32768, -32'sd32768,
                          32'd32768, 32'd32768, 32'd32768, 32'd39322};
      endcase
      write_config();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        calm = (ph == 4) && (n >= PHASE_ITEMS - 60);
        random_item();
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("voxel_view_visibility_clear verification clean");
    end else begin
      $display("voxel_view_visibility_clear verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
